@@ hw/rtl/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, opcodes and status codes of the stack machine execute unit.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int unsigned StackDepthDefault   = 256;
	localparam int unsigned ProgramDepthDefault = 1024;
	localparam int unsigned DataW = 32;

	typedef enum logic [4:0] {
		OP_NOP = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_DUP = 5'd3, OP_INDUP = 5'd4,
		OP_SWAP = 5'd5, OP_INSWAP = 5'd6, OP_ADD = 5'd7, OP_SUB = 5'd8, OP_MUL = 5'd9,
		OP_DIV = 5'd10, OP_MOD = 5'd11, OP_CEQ = 5'd12, OP_CNE = 5'd13, OP_CGT = 5'd14,
		OP_CLT = 5'd15, OP_CGE = 5'd16, OP_CLE = 5'd17, OP_JMP = 5'd18, OP_ZJMP = 5'd19,
		OP_NZJMP = 5'd20, OP_PRINT = 5'd21, OP_HALT = 5'd22
	} op_t;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_END   = 3'd2;
	localparam logic [2:0] ST_OVER  = 3'd3;
	localparam logic [2:0] ST_UNDER = 3'd4;
	localparam logic [2:0] ST_INDEX = 3'd5;
	localparam logic [2:0] ST_DIVZ  = 3'd6;
	localparam logic [2:0] ST_JUMP  = 3'd7;

	// datapath steps commanded by the controller
	typedef enum logic [3:0] {
		DP_IDLE, DP_LATCH, DP_RD_A, DP_RD_B, DP_RD_X, DP_EXEC, DP_DIV_START,
		DP_WR1, DP_WR2, DP_FINISH
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic div_busy;
		logic need_x;
		logic is_div;
		logic stopped;
	} stat_t;

endpackage

@@ hw/rtl/sme_ram.sv @@
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sme_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ hw/rtl/sme_div.sv @@
// ----------------------------------------------------------------------------
// sme_div
// Signed radix-2 divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sme_div
	import sme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] dividend,
	input  logic [DataW-1:0] divisor,
	output logic             busy,
	output logic [DataW-1:0] quotient,
	output logic [DataW-1:0] remainder
);
	logic [DataW-1:0] q_q, r_q, d_q;
	logic [5:0] cnt_q;
	logic neg_q_q, neg_r_q;
	logic [DataW:0] trial;

	assign trial = {r_q, q_q[DataW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(DataW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q     <= dividend[DataW-1] ? -dividend : dividend;
			d_q     <= divisor[DataW-1] ? -divisor : divisor;
			r_q     <= '0;
			neg_q_q <= dividend[DataW-1] ^ divisor[DataW-1];
			neg_r_q <= dividend[DataW-1];
		end else if (cnt_q != '0) begin
			if (!trial[DataW]) begin
				r_q <= trial[DataW-1:0];
				q_q <= {q_q[DataW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DataW-2:0], q_q[DataW-1]};
				q_q <= {q_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = neg_q_q ? -q_q : q_q;
	assign remainder = neg_r_q ? -r_q : r_q;
endmodule

@@ hw/rtl/sme_datapath.sv @@
// ----------------------------------------------------------------------------
// sme_datapath
// Stack memory, operand registers, ALU, checks and architectural state.
// ----------------------------------------------------------------------------
module sme_datapath
	import sme_pkg::*;
#(
	parameter int unsigned StackDepth   = StackDepthDefault,
	parameter int unsigned ProgramDepth = ProgramDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output stat_t       stat,
	input  logic [4:0]  opcode,
	input  logic [31:0] operand,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data,
	output logic [10:0] next_pc,
	output logic        print_valid,
	output logic [31:0] print_value,
	output logic [2:0]  status,
	output logic [8:0]  stack_depth
);
	localparam int unsigned AW = $clog2(StackDepth);
	localparam int unsigned DW = $clog2(StackDepth + 1);
	localparam int unsigned PW = $clog2(ProgramDepth + 1);

	logic [10:0] plen_q;
	logic [PW-1:0] len;
	logic [DW-1:0] dep_q, ndep_q;
	logic [PW-1:0] pc_q, npc_q;
	logic [2:0] stop_q, err_q;
	logic halt_q, pv_q;
	op_t op_q;
	logic [31:0] imm_q, a_q, b_q, x_q, w1_q, w2_q;
	logic [AW-1:0] a1_q, a2_q;
	logic wr1_q, wr2_q;
	logic [AW-1:0] ram_addr;
	logic ram_we;
	logic [31:0] ram_wdata, ram_rdata;
	logic [31:0] quo, rem;
	logic div_busy;
	logic idx_ok, tgt_ok, div_op;
	logic print_ok;

	assign len = (plen_q > 11'(ProgramDepth)) ? PW'(ProgramDepth) : PW'(plen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (cfg_we) begin
			plen_q <= cfg_data;
		end
	end

	sme_ram #(.Width(32), .Depth(StackDepth)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	sme_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.cmd == DP_DIV_START),
		.dividend(a_q), .divisor(b_q), .busy(div_busy), .quotient(quo), .remainder(rem)
	);

	assign idx_ok = !imm_q[31] && ({1'b0, imm_q} < 33'(dep_q));
	assign tgt_ok = !imm_q[31] && ({1'b0, imm_q} < 33'(len));
	assign div_op = (op_q == OP_DIV) || (op_q == OP_MOD);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = w1_q;
		ram_addr  = AW'(dep_q - DW'(1));
		unique case (ctl.cmd)
			DP_RD_B: ram_addr = AW'(dep_q - DW'(2));
			DP_RD_X: ram_addr = imm_q[AW-1:0];
			DP_WR1: begin
				ram_we = wr1_q;
				ram_addr = a1_q;
			end
			DP_WR2: begin
				ram_we = wr2_q;
				ram_addr = a2_q;
				ram_wdata = w2_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_q  <= '0;
			pc_q   <= '0;
			stop_q <= ST_RUN;
		end else if (ctl.cmd == DP_FINISH && stop_q == ST_RUN) begin
			if (pc_q >= len) begin
				stop_q <= ST_END;
			end else if (err_q != ST_RUN) begin
				stop_q <= err_q;
			end else begin
				dep_q <= ndep_q;
				pc_q  <= npc_q;
				if (halt_q) begin
					stop_q <= ST_HALT;
				end else if (npc_q >= len) begin
					stop_q <= ST_END;
				end
			end
		end
	end

	// payload and per-item scratch
	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			DP_LATCH: begin
				op_q  <= op_t'(opcode);
				imm_q <= operand;
				a_q   <= '0;
				b_q   <= '0;
			end
			DP_RD_A: ;
			DP_RD_B: if (dep_q >= DW'(1)) a_q <= ram_rdata;
			DP_RD_X: if (dep_q >= DW'(2)) b_q <= ram_rdata;
			DP_EXEC: begin
				if (stat.need_x) x_q <= ram_rdata;
				else if (dep_q >= DW'(2)) b_q <= ram_rdata;
			end
			default: ;
		endcase
		if (ctl.cmd == DP_LATCH) begin
			err_q  <= ST_RUN;
			halt_q <= 1'b0;
			pv_q   <= 1'b0;
			wr1_q  <= 1'b0;
			wr2_q  <= 1'b0;
		end
		if (ctl.cmd == DP_WR1) begin
			npc_q  <= pc_q + PW'(1);
			ndep_q <= dep_q;
			a1_q   <= AW'(dep_q);
			a2_q   <= AW'(dep_q - DW'(2));
			unique case (op_q)
				OP_PUSH: if (dep_q >= DW'(StackDepth)) err_q <= ST_OVER;
					else begin
						w1_q <= imm_q; wr1_q <= 1'b1; ndep_q <= dep_q + DW'(1);
					end
				OP_POP: if (dep_q < DW'(1)) err_q <= ST_UNDER;
					else ndep_q <= dep_q - DW'(1);
				OP_DUP: if (dep_q < DW'(1)) err_q <= ST_UNDER;
					else if (dep_q >= DW'(StackDepth)) err_q <= ST_OVER;
					else begin
						w1_q <= a_q; wr1_q <= 1'b1; ndep_q <= dep_q + DW'(1);
					end
				OP_INDUP: if (!idx_ok) err_q <= ST_INDEX;
					else if (dep_q >= DW'(StackDepth)) err_q <= ST_OVER;
					else begin
						w1_q <= x_q; wr1_q <= 1'b1; ndep_q <= dep_q + DW'(1);
					end
				OP_SWAP: if (dep_q < DW'(2)) err_q <= ST_UNDER;
					else begin
						a1_q <= AW'(dep_q - DW'(1)); w1_q <= b_q; wr1_q <= 1'b1;
						w2_q <= a_q; wr2_q <= 1'b1;
					end
				OP_INSWAP: if (!idx_ok) err_q <= ST_INDEX;
					else begin
						a1_q <= AW'(dep_q - DW'(1)); w1_q <= x_q; wr1_q <= 1'b1;
						a2_q <= imm_q[AW-1:0]; w2_q <= a_q; wr2_q <= 1'b1;
					end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
					if (dep_q < DW'(2)) err_q <= ST_UNDER;
					else if (div_op && b_q == '0) err_q <= ST_DIVZ;
					else begin
						a1_q <= AW'(dep_q - DW'(2)); wr1_q <= 1'b1;
						ndep_q <= dep_q - DW'(1);
						unique case (op_q)
							OP_ADD: w1_q <= a_q + b_q;
							OP_SUB: w1_q <= a_q - b_q;
							OP_MUL: w1_q <= a_q * b_q;
							OP_DIV: w1_q <= quo;
							default: w1_q <= rem;
						endcase
					end
				OP_CEQ, OP_CNE, OP_CGT, OP_CLT, OP_CGE, OP_CLE:
					if (dep_q < DW'(2)) err_q <= ST_UNDER;
					else if (dep_q >= DW'(StackDepth)) err_q <= ST_OVER;
					else begin
						wr1_q <= 1'b1; ndep_q <= dep_q + DW'(1);
						unique case (op_q)
							OP_CEQ: w1_q <= 32'(a_q == b_q);
							OP_CNE: w1_q <= 32'(a_q != b_q);
							OP_CGT: w1_q <= 32'($signed(a_q) > $signed(b_q));
							OP_CLT: w1_q <= 32'($signed(a_q) < $signed(b_q));
							OP_CGE: w1_q <= 32'($signed(a_q) >= $signed(b_q));
							default: w1_q <= 32'($signed(a_q) <= $signed(b_q));
						endcase
					end
				OP_JMP: if (!tgt_ok) err_q <= ST_JUMP;
					else npc_q <= PW'(imm_q[PW-1:0]);
				OP_ZJMP, OP_NZJMP:
					if (dep_q < DW'(1)) err_q <= ST_UNDER;
					else if ((op_q == OP_ZJMP) == (a_q == '0)) begin
						if (!tgt_ok) err_q <= ST_JUMP;
						else begin
							npc_q <= PW'(imm_q[PW-1:0]); ndep_q <= dep_q - DW'(1);
						end
					end else ndep_q <= dep_q - DW'(1);
				OP_PRINT: if (dep_q < DW'(1)) err_q <= ST_UNDER;
					else begin
						pv_q <= 1'b1; w2_q <= a_q; ndep_q <= dep_q - DW'(1);
					end
				OP_HALT: halt_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.need_x   = (op_q == OP_INDUP) || (op_q == OP_INSWAP);
	// divisor is still loading when this is sampled; zero is caught at the check
	assign stat.is_div   = div_op && (dep_q >= DW'(2));
	assign stat.stopped  = (stop_q != ST_RUN) || (pc_q >= len);

	assign print_ok = pv_q && err_q == ST_RUN;

	assign next_pc     = 11'(pc_q);
	assign print_valid = print_ok;
	assign print_value = print_ok ? w2_q : '0;
	assign status      = stop_q;
	assign stack_depth = 9'(dep_q);
endmodule

@@ hw/rtl/sme_ctrl.sv @@
// ----------------------------------------------------------------------------
// sme_ctrl
// Sequencer: read operands, run the divider, compute, write back, report.
// ----------------------------------------------------------------------------
module sme_ctrl
	import sme_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output logic  cfg_ready,
	output ctl_t  ctl,
	input  stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE, S_RD_A, S_RD_B, S_RD_X, S_EXEC, S_DIV, S_DIVW, S_WR1, S_CHK, S_WR2, S_FIN,
		S_OUT
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		ctl.cmd = DP_IDLE;
		unique case (state_q)
			S_IDLE: if (in_valid) ctl.cmd = DP_LATCH;
			S_RD_A: ctl.cmd = DP_RD_A;
			S_RD_B: ctl.cmd = DP_RD_B;
			S_RD_X: ctl.cmd = DP_RD_X;
			S_EXEC: ctl.cmd = DP_EXEC;
			S_DIV:  ctl.cmd = DP_DIV_START;
			S_CHK:  ctl.cmd = DP_WR1;
			S_WR1:  ctl.cmd = DP_WR1;
			S_WR2:  ctl.cmd = DP_WR2;
			S_FIN:  ctl.cmd = DP_FINISH;
			default: ;
		endcase
	end

	// CHK computes the decision into the scratch registers, WR1 writes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= stat.stopped ? S_FIN : S_RD_A;
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: state_q <= stat.need_x ? S_RD_X : S_EXEC;
				S_RD_X: state_q <= S_EXEC;
				S_EXEC: state_q <= stat.is_div ? S_DIV : S_CHK;
				S_DIV:  state_q <= S_DIVW;
				S_DIVW: if (!stat.div_busy) state_q <= S_CHK;
				S_CHK:  state_q <= S_WR1;
				S_WR1:  state_q <= S_WR2;
				S_WR2:  state_q <= S_FIN;
				S_FIN:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/stack_machine_execute_top.sv @@
// Stack machine execute unit. Takes one instruction (opcode, operand) per
// request and returns the next fetch address, print data, status and stack
// depth. A request is taken only once the previous result has been accepted.
// Each instruction runs the operand reads (a third read for indup and
// inswap), the check and two write steps on the single-port stack RAM; div
// and mod also wait on the bit-serial divider. A stopped block only reports.
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
module stack_machine_execute_top
	import sme_pkg::*;
#(
	parameter int unsigned StackDepth   = StackDepthDefault,
	parameter int unsigned ProgramDepth = ProgramDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  opcode,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] next_pc,
	output logic        print_valid,
	output logic [31:0] print_value,
	output logic [2:0]  status,
	output logic [8:0]  stack_depth,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] program_length
);
	ctl_t  ctl;
	stat_t stat;

	sme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cfg_ready(cfg_ready), .ctl(ctl), .stat(stat)
	);

	sme_datapath #(.StackDepth(StackDepth), .ProgramDepth(ProgramDepth)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat), .opcode(opcode),
		.operand(operand), .cfg_we(cfg_valid && cfg_ready), .cfg_data(program_length),
		.next_pc(next_pc), .print_valid(print_valid), .print_value(print_value),
		.status(status), .stack_depth(stack_depth)
	);

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_print_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && print_valid |-> status == ST_RUN || status == ST_END)
		else $error("print on stop");
endmodule

@@ verif/sme_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sme_checker
// Watches the request, result and register channels of the stack machine
// execute unit, predicts each result from its own copy of the machine state
// and compares the results field by field in order.
// ----------------------------------------------------------------------------
module sme_checker
	import sme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [4:0]  opcode,
	input  logic [31:0] operand,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [10:0] next_pc,
	input  logic        print_valid,
	input  logic [31:0] print_value,
	input  logic [2:0]  status,
	input  logic [8:0]  stack_depth,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] program_length,
	output int          pending,
	output int          fails
);

	typedef struct {
		logic [10:0] pc;
		logic        pvalid;
		logic [31:0] pvalue;
		logic [2:0]  stat;
		logic [8:0]  depth;
	} exec_result_t;

	exec_result_t awaited_q[$];

	logic [31:0] stk[StackDepthDefault];
	int unsigned depth;
	int unsigned pc;
	logic [2:0]  stop;
	logic [10:0] plen;

	task automatic execute_instr(input logic [4:0] op, input logic [31:0] opnd);
		int unsigned len;
		int unsigned nxt;
		longint imm;
		longint sa;
		longint sb;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		logic [2:0]  err;
		logic        halt;
		logic        take;
		logic        c;
		exec_result_t res;
		len = (plen > ProgramDepthDefault) ? ProgramDepthDefault : plen;
		nxt = pc + 1;
		imm = longint'($signed(opnd));
		err = ST_RUN;
		halt = 1'b0;
		res.pvalid = 1'b0;
		res.pvalue = '0;
		a = (depth >= 1) ? stk[depth - 1] : '0;
		b = (depth >= 2) ? stk[depth - 2] : '0;
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		if (stop != ST_RUN) begin
			// stopped: nothing changes
		end else if (pc >= len) begin
			stop = ST_END;
		end else begin
			case (op)
				OP_PUSH: begin
					if (depth >= StackDepthDefault) err = ST_OVER;
					else begin
						stk[depth] = opnd;
						depth++;
					end
				end
				OP_POP: begin
					if (depth < 1) err = ST_UNDER;
					else depth--;
				end
				OP_DUP: begin
					if (depth < 1) err = ST_UNDER;
					else if (depth >= StackDepthDefault) err = ST_OVER;
					else begin
						stk[depth] = a;
						depth++;
					end
				end
				OP_INDUP: begin
					if (imm < 0 || imm >= longint'(depth)) err = ST_INDEX;
					else if (depth >= StackDepthDefault) err = ST_OVER;
					else begin
						stk[depth] = stk[imm];
						depth++;
					end
				end
				OP_SWAP: begin
					if (depth < 2) err = ST_UNDER;
					else begin
						stk[depth - 1] = b;
						stk[depth - 2] = a;
					end
				end
				OP_INSWAP: begin
					if (imm < 0 || imm >= longint'(depth)) err = ST_INDEX;
					else begin
						stk[depth - 1] = stk[imm];
						stk[imm] = a;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
					if (depth < 2) err = ST_UNDER;
					else if ((op == OP_DIV || op == OP_MOD) && b == '0) err = ST_DIVZ;
					else begin
						case (op)
							OP_ADD:  r = a + b;
							OP_SUB:  r = a - b;
							OP_MUL:  r = a * b;
							OP_DIV:  r = 32'(sa / sb);
							default: r = 32'(sa % sb);
						endcase
						stk[depth - 2] = r;
						depth--;
					end
				end
				OP_CEQ, OP_CNE, OP_CGT, OP_CLT, OP_CGE, OP_CLE: begin
					if (depth < 2) err = ST_UNDER;
					else if (depth >= StackDepthDefault) err = ST_OVER;
					else begin
						case (op)
							OP_CEQ:  c = (sa == sb);
							OP_CNE:  c = (sa != sb);
							OP_CGT:  c = (sa > sb);
							OP_CLT:  c = (sa < sb);
							OP_CGE:  c = (sa >= sb);
							default: c = (sa <= sb);
						endcase
						stk[depth] = {31'd0, c};
						depth++;
					end
				end
				OP_JMP: begin
					if (imm < 0 || imm >= longint'(len)) err = ST_JUMP;
					else nxt = int'(imm);
				end
				OP_ZJMP, OP_NZJMP: begin
					if (depth < 1) err = ST_UNDER;
					else begin
						take = (op == OP_ZJMP) ? (a == '0) : (a != '0);
						if (take && (imm < 0 || imm >= longint'(len))) err = ST_JUMP;
						else begin
							if (take) nxt = int'(imm);
							depth--;
						end
					end
				end
				OP_PRINT: begin
					if (depth < 1) err = ST_UNDER;
					else begin
						res.pvalid = 1'b1;
						res.pvalue = a;
						depth--;
					end
				end
				OP_HALT: halt = 1'b1;
				default: ;
			endcase
			if (err != ST_RUN) begin
				stop = err;
			end else begin
				pc = nxt;
				if (halt) stop = ST_HALT;
				else if (nxt >= len) stop = ST_END;
			end
		end
		res.pc = 11'(pc);
		res.stat = stop;
		res.depth = 9'(depth);
		awaited_q.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fails = fails + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_result_t e;
		if (!arst_n) begin
			awaited_q.delete();
			depth = 0;
			pc = 0;
			stop = ST_RUN;
			plen = '0;
			pending <= 0;
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) plen = program_length;
			if (in_valid && in_ready) execute_instr(opcode, operand);
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					$error("result with no request waiting: next_pc %0h", next_pc);
					fails = fails + 1;
				end else begin
					e = awaited_q.pop_front();
					check_field("next_pc", 32'(e.pc), 32'(next_pc));
					check_field("print_valid", 32'(e.pvalid), 32'(print_valid));
					check_field("print_value", e.pvalue, print_value);
					check_field("status", 32'(e.stat), 32'(status));
					check_field("stack_depth", 32'(e.depth), 32'(stack_depth));
				end
			end
			pending <= awaited_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives well-formed instruction streams with random content into the stack
// machine execute unit under random sender bursts and receiver stalls, steps
// through several program lengths and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb
	import sme_pkg::*;
;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  opcode = '0;
	logic [31:0] operand = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [10:0] next_pc;
	logic        print_valid;
	logic [31:0] print_value;
	logic [2:0]  status;
	logic [8:0]  stack_depth;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] program_length = '0;
	int          pending;
	int          fails;

	// shadow of pc and depth, enough to keep the program running
	int unsigned gen_pc;
	int unsigned gen_depth;
	int unsigned gen_len;
	logic [31:0] last_push;
	int          burst_left;
	int          sent;

	always #1 clk = ~clk;

	stack_machine_execute_top i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .operand,
		.out_valid, .out_ready, .next_pc, .print_valid, .print_value,
		.status, .stack_depth, .cfg_valid, .cfg_ready, .program_length
	);

	sme_checker i_checker (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .operand,
		.out_valid, .out_ready, .next_pc, .print_valid, .print_value,
		.status, .stack_depth, .cfg_valid, .cfg_ready, .program_length,
		.pending, .fails
	);

	// receiver: switch between always ready, random and mostly stalled
	initial begin
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_request(input logic [4:0] op, input logic [31:0] opnd);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		operand <= opnd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic issue(input logic [4:0] op, input logic [31:0] opnd);
		logic take;
		send_request(op, opnd);
		gen_pc++;
		case (op)
			OP_PUSH: begin
				gen_depth++;
				last_push = opnd;
			end
			OP_DUP, OP_INDUP, OP_CEQ, OP_CNE, OP_CGT, OP_CLT, OP_CGE, OP_CLE:
				gen_depth++;
			OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_PRINT:
				gen_depth--;
			OP_JMP: gen_pc = opnd;
			OP_ZJMP, OP_NZJMP: begin
				take = (op == OP_ZJMP) ? (last_push == '0) : (last_push != '0);
				if (take) gen_pc = opnd;
				gen_depth--;
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_length(input logic [10:0] len);
		cfg_valid <= 1'b1;
		program_length <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		gen_len = (len > ProgramDepthDefault) ? ProgramDepthDefault : len;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return $urandom_range(0, 9);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_step();
		int sel;
		logic [31:0] v;
		sel = $urandom_range(0, 99);
		if (gen_pc + 8 >= gen_len) begin
			issue(OP_JMP, $urandom_range(0, gen_len / 2));
		end else if (gen_depth < 3) begin
			issue(OP_PUSH, pick_value());
		end else if (gen_depth > 240) begin
			issue(($urandom_range(0, 1) != 0) ? OP_POP : OP_PRINT, $urandom);
		end else if (sel < 22) begin
			issue(OP_PUSH, pick_value());
		end else if (sel < 28) begin
			issue(OP_POP, $urandom);
		end else if (sel < 32) begin
			issue(OP_DUP, $urandom);
		end else if (sel < 37) begin
			issue(OP_INDUP, $urandom_range(0, gen_depth - 1));
		end else if (sel < 41) begin
			issue(OP_SWAP, $urandom);
		end else if (sel < 46) begin
			issue(OP_INSWAP, $urandom_range(0, gen_depth - 1));
		end else if (sel < 58) begin
			issue(5'($urandom_range(OP_ADD, OP_MUL)), $urandom);
		end else if (sel < 66) begin
			// divisor below, dividend on top
			v = pick_value();
			if (v == '0) v = 32'hFFFF_FFFF;
			issue(OP_PUSH, v);
			issue(OP_PUSH, pick_value());
			issue(5'($urandom_range(OP_DIV, OP_MOD)), $urandom);
		end else if (sel < 78) begin
			issue(5'($urandom_range(OP_CEQ, OP_CLE)), $urandom);
		end else if (sel < 82) begin
			issue(OP_JMP, $urandom_range(0, gen_len - 10));
		end else if (sel < 90) begin
			issue(OP_PUSH, ($urandom_range(0, 1) != 0) ? 32'd0 : pick_value());
			issue(5'($urandom_range(OP_ZJMP, OP_NZJMP)), $urandom_range(0, gen_len - 10));
		end else if (sel < 94) begin
			issue(OP_PRINT, $urandom);
		end else begin
			issue(($urandom_range(0, 3) == 0) ? OP_NOP : 5'($urandom_range(23, 31)), $urandom);
		end
	endtask

	initial begin
		gen_pc = 0;
		gen_depth = 0;
		gen_len = 0;
		last_push = '0;
		burst_left = 0;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest length, clamped to the program store
		write_length(11'h7FF);

		issue(OP_PUSH, 32'h7FFF_FFFF);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_PUSH, 32'h0000_0000);
		issue(OP_DUP, 32'd0);
		issue(OP_INDUP, 32'd0);
		issue(OP_INDUP, gen_depth - 1);
		issue(OP_SWAP, 32'd0);
		issue(OP_INSWAP, 32'd0);
		issue(OP_ADD, 32'd0);
		issue(OP_SUB, 32'd0);
		issue(OP_MUL, 32'd0);
		for (int op = OP_CEQ; op <= OP_CLE; op++) issue(5'(op), 32'd0);
		issue(OP_POP, 32'd0);
		issue(OP_NOP, 32'hFFFF_FFFF);
		issue(5'd31, 32'h5A5A_A5A5);
		// most negative divided by minus one wraps, remainder zero
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_DIV, 32'd0);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_PUSH, 32'h8000_0000);
		issue(OP_MOD, 32'd0);
		issue(OP_PRINT, 32'd0);
		issue(OP_PUSH, 32'd0);
		issue(OP_ZJMP, 32'd40);
		issue(OP_PUSH, 32'd7);
		issue(OP_NZJMP, 32'd3);
		issue(OP_PUSH, 32'd0);
		issue(OP_NZJMP, 32'd900);
		issue(OP_JMP, 32'd0);

		while (sent < 220) random_step();
		issue(OP_JMP, 32'd0);
		drain();
		write_length(11'd1024);
		while (sent < 370) random_step();
		issue(OP_JMP, 32'd0);
		drain();
		write_length(11'd600);
		while (sent < 500) random_step();

		issue(OP_HALT, 32'd0);
		// stopped: these repeat the last state
		issue(OP_PUSH, 32'd1);
		issue(OP_PRINT, 32'd0);
		drain();
		write_length(11'd0);
		issue(OP_POP, 32'd0);
		issue(OP_JMP, 32'd0);
		drain();
		repeat (60) @(posedge clk);

		if (fails == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
